// ===== hdl/pcrm_pkg.sv =====
// Shared types and constants for the per-cell running mean and peak block.
// Holds grid sizing, register indexes, the item structs and the control structs.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pcrm_pkg;

    // Grid size and cell store depth.
    localparam int GRID_X      = 64;
    localparam int GRID_Y      = 64;
    localparam int ADDR_W      = 12;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int CELL_COUNT  = GRID_X * GRID_Y;
    localparam int CELL_LIMIT  = (CELL_COUNT < STORE_DEPTH) ? CELL_COUNT : STORE_DEPTH;
    localparam logic [ADDR_W:0] CELL_LIMIT_V = (ADDR_W + 1)'(CELL_LIMIT);

    // Field widths.
    localparam int RHO_W   = 24;
    localparam int LEVEL_W = 17;
    localparam int FRAME_W = 24;

    // Shared divider: quotient bits, one per cycle.
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN    = 2'd2;

    localparam logic [RHO_W-1:0] BASE_RESET = 24'd1048576;
    localparam logic [RHO_W-1:0] SPAN_RESET = 24'd10486;

    typedef struct packed {
        logic [ADDR_W-1:0] cell_index;
        logic [RHO_W-1:0]  rho_sample;
        logic              new_frame;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0]  cell_index_out;
        logic [LEVEL_W-1:0] mean_level;
        logic [RHO_W-1:0]   peak_excess;
        logic [FRAME_W-1:0] frames_seen;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_NORM_GO,
        ST_NORM_WAIT,
        ST_SQUARE,
        ST_SUM,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_WRITE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic prep;
        logic norm_start;
        logic square;
        logic sum;
        logic mean_start;
        logic write;
        logic clear_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic div_done;
        logic update;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/per_cell_running_mean_and_peak.sv =====
// Top level of the per-cell running mean and peak block.
// Joins pcrm_ctrl and pcrm_datapath; depends on pcrm_pkg.
//
//   Channel   Direction  Handshake                     Payload
//   input     in         i_in_valid / o_in_ready       i_in_data   (t_in)
//   output    out        o_out_valid / i_out_ready     o_out_data  (t_out)
//   config    in         i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// After reset a sweep zeroes both cell stores; no item is taken until it ends.
// An enabled item on a valid cell makes two passes of the shared divider, at
// one quotient bit per cycle, and no new item is accepted until it is written.
// A disabled item or a cell outside the grid skips the divider. A full output
// register holds the item in its last step until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module per_cell_running_mean_and_peak (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcrm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pcrm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire pcrm_pkg::t_in                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output pcrm_pkg::t_out                         o_out_data
);
    import pcrm_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    pcrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Stores, arithmetic and output register.
    pcrm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/pcrm_div.sv =====
// Shared restoring divider: one quotient bit per cycle, 17 quotient bits.
// The caller supplies a starting remainder below the divisor plus the low bits.
// Depends on pcrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcrm_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pcrm_pkg::RHO_W-1:0]     i_rem_init,
    input  wire logic [pcrm_pkg::LEVEL_W-1:0]   i_low,
    input  wire logic [pcrm_pkg::RHO_W-1:0]     i_divisor,
    output logic                                o_done,
    output logic [pcrm_pkg::LEVEL_W-1:0]        o_quot
);
    import pcrm_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [RHO_W-1:0]     r_rem;
    logic [LEVEL_W-1:0]   r_low;
    logic [RHO_W-1:0]     r_div;
    logic [LEVEL_W-1:0]   r_quot;

    logic [RHO_W:0]   trial;
    logic [RHO_W:0]   diff;
    logic             ge;
    logic [RHO_W-1:0] n_rem;

    // One compare and subtract step.
    always_comb begin
        trial = {r_rem, r_low[LEVEL_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[RHO_W-1:0] : trial[RHO_W-1:0];
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder, numerator bits and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem_init;
            r_low  <= i_low;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_low  <= {r_low[LEVEL_W-2:0], 1'b0};
            r_quot <= {r_quot[LEVEL_W-2:0], ge};
        end
    end

    // The quotient is final after the edge at which done is high.
    assign o_done = r_busy && (r_cnt == DIV_LAST);
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== hdl/pcrm_datapath.sv =====
// Datapath: configuration registers, cell stores, frame counter, arithmetic
// and the output register. Depends on pcrm_pkg and pcrm_div.
`timescale 1ns / 1ps
`default_nettype none

module pcrm_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pcrm_pkg::t_cmd                    i_cmd,
    output pcrm_pkg::t_status                      o_status,
    input  wire logic                              i_cfg_we,
    input  wire logic [pcrm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [pcrm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire pcrm_pkg::t_in                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output pcrm_pkg::t_out                         o_out_data
);
    import pcrm_pkg::*;

    // Configuration registers.
    logic             r_enabled;
    logic [RHO_W-1:0] r_base;
    logic [RHO_W-1:0] r_span;

    // Cell stores.
    logic [LEVEL_W-1:0] mem_mean [STORE_DEPTH];
    logic [RHO_W-1:0]   mem_peak [STORE_DEPTH];

    logic [ADDR_W-1:0]  r_clr_addr;
    logic [FRAME_W-1:0] r_frames;

    // Item in flight.
    logic [ADDR_W-1:0]    r_idx;
    logic [RHO_W-1:0]     r_rho;
    logic [LEVEL_W-1:0]   r_mean_rd;
    logic [RHO_W-1:0]     r_peak_rd;
    logic [RHO_W-1:0]     r_ex;
    logic [FRAME_W-1:0]   r_n;
    logic [FRAME_W-1:0]   r_nm1;
    logic [LEVEL_W-1:0]   r_sq;
    logic [40:0]          r_prod;
    logic [41:0]          r_num;

    logic                 r_out_valid;
    t_out                 r_out;

    logic                 cell_ok;
    logic                 update;
    logic [RHO_W-1:0]     d_clamped;
    logic                 div_start;
    logic [RHO_W-1:0]     div_rem_init;
    logic [LEVEL_W-1:0]   div_low;
    logic [RHO_W-1:0]     div_divisor;
    logic                 div_done;
    logic [LEVEL_W-1:0]   div_quot;
    logic [LEVEL_W-1:0]   level;
    logic [33:0]          level_sq;
    logic [LEVEL_W-1:0]   new_mean;
    logic [RHO_W-1:0]     new_peak;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [LEVEL_W-1:0]   mem_wmean;
    logic [RHO_W-1:0]     mem_wpeak;
    t_out                 n_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_base    <= BASE_RESET;
            r_span    <= SPAN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLED: r_enabled <= i_cfg_data[0];
                CFG_BASE:    r_base    <= i_cfg_data;
                CFG_SPAN:    r_span    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Clearing sweep address and the saturating frame counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_frames   <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.accept && r_enabled && i_in_data.new_frame
                    && (r_frames != FRAME_MAX)) begin
                r_frames <= r_frames + 1'b1;
            end
        end
    end

    assign cell_ok = ({1'b0, r_idx} < CELL_LIMIT_V);
    assign update  = r_enabled && cell_ok;

    // Store write port: zeros during the sweep, new values on item write.
    always_comb begin
        new_mean  = update ? div_quot : r_mean_rd;
        new_peak  = (update && (r_ex > r_peak_rd)) ? r_ex : r_peak_rd;
        mem_we    = i_cmd.clear_step || (i_cmd.write && update);
        mem_waddr = i_cmd.clear_step ? r_clr_addr : r_idx;
        mem_wmean = i_cmd.clear_step ? '0 : new_mean;
        mem_wpeak = i_cmd.clear_step ? '0 : new_peak;
    end

    // Cell stores with registered reads at acceptance.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_mean[mem_waddr] <= mem_wmean;
            mem_peak[mem_waddr] <= mem_wpeak;
        end
        if (i_cmd.accept) begin
            r_mean_rd <= mem_mean[i_in_data.cell_index];
            r_peak_rd <= mem_peak[i_in_data.cell_index];
        end
    end

    // Divider operands: normalization first, then the mean update.
    always_comb begin
        d_clamped    = (r_ex > r_span) ? r_span : r_ex;
        div_start    = i_cmd.norm_start || i_cmd.mean_start;
        div_rem_init = i_cmd.norm_start ? {1'b0, d_clamped[RHO_W-1:1]} : r_num[40:17];
        div_low      = i_cmd.norm_start ? {d_clamped[0], 16'b0} : r_num[LEVEL_W-1:0];
        div_divisor  = i_cmd.norm_start ? r_span : r_n;
    end

    pcrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_rem_init (div_rem_init),
        .i_low      (div_low),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // A zero span gives a level of zero.
    always_comb begin
        level    = (r_span == '0) ? '0 : div_quot;
        level_sq = {17'b0, level} * {17'b0, level};
    end

    // Item registers and arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= i_in_data.cell_index;
            r_rho <= i_in_data.rho_sample;
        end
        if (i_cmd.prep) begin
            r_ex  <= (r_rho > r_base) ? (r_rho - r_base) : '0;
            r_n   <= (r_frames == '0) ? FRAME_W'(1) : r_frames;
            r_nm1 <= (r_frames == '0) ? '0 : (r_frames - 1'b1);
        end
        if (i_cmd.square) begin
            r_sq   <= level_sq[32:16];
            r_prod <= {24'b0, r_mean_rd} * {17'b0, r_nm1};
        end
        if (i_cmd.sum) begin
            r_num <= {1'b0, r_prod} + {25'b0, r_sq};
        end
    end

    // Result assembly: cells outside the grid report a zero mean and peak.
    always_comb begin
        n_out.cell_index_out = r_idx;
        n_out.mean_level     = cell_ok ? new_mean : '0;
        n_out.peak_excess    = cell_ok ? new_peak : '0;
        n_out.frames_seen    = r_frames;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_status.clear_last = (r_clr_addr == '1);
        o_status.div_done   = div_done;
        o_status.update     = update;
        o_status.out_busy   = r_out_valid && !i_out_ready;
    end

endmodule

`default_nettype wire

// ===== hdl/pcrm_ctrl.sv =====
// Controller state machine: clearing sweep, item sequencing, output handoff.
// Depends on pcrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcrm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire pcrm_pkg::t_status i_status,
    output pcrm_pkg::t_cmd         o_cmd
);
    import pcrm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_status.update ? ST_NORM_GO : ST_WRITE;
            end
            ST_NORM_GO: begin
                o_cmd.norm_start = 1'b1;
                n_state          = ST_NORM_WAIT;
            end
            ST_NORM_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_MEAN_GO;
            end
            ST_MEAN_GO: begin
                o_cmd.mean_start = 1'b1;
                n_state          = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // Hold until the output register can take the item.
                if (!i_status.out_busy) begin
                    o_cmd.write = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/per_cell_running_mean_and_peak_tb.sv =====
// Self-checking testbench for per_cell_running_mean_and_peak.
// A directed table and randomized phases are checked against a cell-statistics predictor
// or known values. Depends on pcrm_pkg and the per_cell_running_mean_and_peak RTL.
`timescale 1ns / 1ps

module per_cell_running_mean_and_peak_tb;
    import pcrm_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 175;
    localparam int END_SETTLE     = 60;
    localparam logic [RHO_W-1:0] RHO_MAX = '1;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        t_in                    item;
        bit                     has_known;
        t_out                   known;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_data;

    // Shadow copy of the block's state and registers.
    logic [LEVEL_W-1:0] mean_map [STORE_DEPTH];
    logic [RHO_W-1:0]   peak_map [STORE_DEPTH];
    logic [FRAME_W-1:0] frame_tally;
    logic               cfg_on;
    logic [RHO_W-1:0]   cfg_base;
    logic [RHO_W-1:0]   cfg_span;

    t_out       pending_stats [$];
    t_stim_row  dir_rows [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;

    // Receiver stall pattern state.
    int         stall_mode = 0;
    int         stall_left = 0;
    t_out       want;

    per_cell_running_mean_and_peak DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Free-running clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Squared normalized level of a sample, Q1.16.
    function automatic longint unsigned norm_square(input logic [RHO_W-1:0] rho);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned c;
        longint unsigned v;
        lo = cfg_base;
        hi = lo + cfg_span;
        c  = rho;
        // A zero-width window gives no level at all.
        if (cfg_span == 0) return 0;
        if (c > hi) c = hi;
        if (c < lo) c = lo;
        v = ((c - lo) << 16) / cfg_span;
        return (v * v) >> 16;
    endfunction

    // Applies one accepted item to the shadow state and returns its result.
    function automatic t_out update_cell_stats(input t_in x);
        t_out            r;
        longint unsigned n;
        longint unsigned prev;
        logic            in_grid;
        in_grid = int'(x.cell_index) < CELL_LIMIT;
        if (cfg_on) begin
            if (x.new_frame && frame_tally != FRAME_MAX) frame_tally++;
            if (in_grid) begin
                // Before the first frame the divisor is taken as one.
                n    = (frame_tally == 0) ? 1 : frame_tally;
                prev = mean_map[x.cell_index];
                mean_map[x.cell_index] = LEVEL_W'((prev * (n - 1) + norm_square(x.rho_sample)) / n);
                if (x.rho_sample > cfg_base &&
                    (x.rho_sample - cfg_base) > peak_map[x.cell_index])
                    peak_map[x.cell_index] = x.rho_sample - cfg_base;
            end
        end
        r.cell_index_out = x.cell_index;
        r.mean_level     = in_grid ? mean_map[x.cell_index] : '0;
        r.peak_excess    = in_grid ? peak_map[x.cell_index] : '0;
        r.frames_seen    = frame_tally;
        return r;
    endfunction

    // Random item, mostly on a few busy cells and inside the density window.
    function automatic t_in gen_item();
        t_in             x;
        longint unsigned lo;
        longint unsigned pick;
        logic [2:0]      low_bits;
        low_bits = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 7)
            x.cell_index = $urandom_range(0, 1) ? (12'hFF8 | low_bits) : 12'(low_bits);
        else
            x.cell_index = 12'($urandom_range(0, 4095));
        lo = cfg_base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: pick = lo + $urandom_range(0, cfg_span);
            6:                pick = $urandom_range(0, cfg_base);
            7:                pick = lo + cfg_span + $urandom_range(1, 4096);
            8:                pick = $urandom() & 32'hFFFFFF;
            default:          pick = $urandom_range(0, 1) ? RHO_MAX : 0;
        endcase
        if (pick > RHO_MAX) pick = RHO_MAX;
        x.rho_sample = RHO_W'(pick);
        x.new_frame  = ($urandom_range(0, 7) == 0);
        return x;
    endfunction

    function automatic t_stim_row row_item(input logic [ADDR_W-1:0] cell_idx,
                                           input logic [RHO_W-1:0] rho, input bit nf);
        t_stim_row r;
        r.kind      = ROW_ITEM;
        r.reg_idx   = '0;
        r.reg_data  = '0;
        r.item      = {cell_idx, rho, nf};
        r.has_known = 1'b0;
        r.known     = '0;
        return r;
    endfunction

    function automatic t_stim_row row_known(input logic [ADDR_W-1:0] cell_idx,
                                            input logic [RHO_W-1:0] rho, input bit nf,
                                            input t_out known);
        t_stim_row r;
        r           = row_item(cell_idx, rho, nf);
        r.has_known = 1'b1;
        r.known     = known;
        return r;
    endfunction

    function automatic t_stim_row row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        t_stim_row r;
        r          = row_item('0, '0, 1'b0);
        r.kind     = ROW_CFG;
        r.reg_idx  = idx;
        r.reg_data = val;
        return r;
    endfunction

    // Writes one register; the caller lowers the write enable after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ENABLED: cfg_on   = val[0];
            CFG_BASE:    cfg_base = val[RHO_W-1:0];
            CFG_SPAN:    cfg_span = val[RHO_W-1:0];
            default: ;
        endcase
    endtask

    // Offers one item, records its expected result on acceptance, then idles for any gap.
    task automatic push_item(input t_in x, input bit has_known, input t_out known,
                             input int gap);
        t_out predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = update_cell_stats(x);
        pending_stats.push_back(has_known ? known : predicted);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_stats.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [23:0] exp_val,
                               input logic [23:0] got_val);
        if (got_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual cell %0d", $time,
                         o_out_data.cell_index_out);
                mismatch_count++;
            end else begin
                want = pending_stats.pop_front();
                check_field("cell_index_out", 24'(want.cell_index_out),
                            24'(o_out_data.cell_index_out));
                check_field("mean_level", 24'(want.mean_level), 24'(o_out_data.mean_level));
                check_field("peak_excess", want.peak_excess, o_out_data.peak_excess);
                check_field("frames_seen", want.frames_seen, o_out_data.frames_seen);
            end
        end
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (cycle_count % 5) != 0;
        endcase
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main stimulus sequence.
    initial begin
        int          gap;
        int          burst_left;
        logic [23:0] base_pick;
        logic [23:0] span_pick;
        burst_left = 0;

        // Shadow state after reset.
        cfg_on      = 1'b0;
        cfg_base    = BASE_RESET;
        cfg_span    = SPAN_RESET;
        frame_tally = '0;
        for (int c = 0; c < STORE_DEPTH; c++) begin
            mean_map[c] = '0;
            peak_map[c] = '0;
        end

        // Reset values: disabled, nothing stored, no frames counted.
        dir_rows.push_back(row_known(12'd0, 24'd0, 1'b1, {12'd0, 17'd0, 24'd0, 24'd0}));
        dir_rows.push_back(row_known(12'd4095, RHO_MAX, 1'b0, {12'd4095, 17'd0, 24'd0, 24'd0}));
        // Enabled with default window; samples before and after the first frame.
        dir_rows.push_back(row_cfg(CFG_ENABLED, 24'd1));
        dir_rows.push_back(row_known(12'd5, 24'd0, 1'b0, {12'd5, 17'd0, 24'd0, 24'd0}));
        dir_rows.push_back(row_known(12'd5, RHO_MAX, 1'b0,
                                     {12'd5, 17'd65536, 24'd15728639, 24'd0}));
        dir_rows.push_back(row_item(12'd5, 24'd1053819, 1'b1));
        dir_rows.push_back(row_item(12'd5, 24'd1059062, 1'b0));
        dir_rows.push_back(row_item(12'd5, 24'd1048576, 1'b0));
        dir_rows.push_back(row_item(12'd4095, 24'd1048577, 1'b1));
        dir_rows.push_back(row_item(12'd0, 24'd1048575, 1'b0));
        // Widest window from zero.
        dir_rows.push_back(row_cfg(CFG_BASE, 24'd0));
        dir_rows.push_back(row_cfg(CFG_SPAN, 24'hFFFFFF));
        dir_rows.push_back(row_item(12'd7, 24'd0, 1'b1));
        dir_rows.push_back(row_item(12'd7, RHO_MAX, 1'b0));
        dir_rows.push_back(row_item(12'd7, 24'd8388608, 1'b1));
        // Base at its top: no sample can exceed it.
        dir_rows.push_back(row_cfg(CFG_BASE, 24'hFFFFFF));
        dir_rows.push_back(row_item(12'd8, RHO_MAX, 1'b0));
        dir_rows.push_back(row_item(12'd8, 24'd0, 1'b1));
        // Narrowest nonzero window.
        dir_rows.push_back(row_cfg(CFG_BASE, 24'd1000));
        dir_rows.push_back(row_cfg(CFG_SPAN, 24'd1));
        dir_rows.push_back(row_item(12'd9, 24'd1000, 1'b0));
        dir_rows.push_back(row_item(12'd9, 24'd1001, 1'b0));
        dir_rows.push_back(row_item(12'd9, 24'd5000, 1'b1));
        // Zero-width window.
        dir_rows.push_back(row_cfg(CFG_SPAN, 24'd0));
        dir_rows.push_back(row_item(12'd9, 24'd5000, 1'b0));
        dir_rows.push_back(row_item(12'd10, RHO_MAX, 1'b1));
        // Disabled: maps and frame counter stay frozen.
        dir_rows.push_back(row_cfg(CFG_ENABLED, 24'd0));
        dir_rows.push_back(row_item(12'd9, 24'd0, 1'b1));
        dir_rows.push_back(row_item(12'd5, RHO_MAX, 1'b0));
        // Back to the default window.
        dir_rows.push_back(row_cfg(CFG_ENABLED, 24'd1));
        dir_rows.push_back(row_cfg(CFG_BASE, BASE_RESET));
        dir_rows.push_back(row_cfg(CFG_SPAN, SPAN_RESET));
        dir_rows.push_back(row_item(12'd5, 24'd1050000, 1'b1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (int k = 0; k < dir_rows.size(); k++) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                wait_drained();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_data);
                if (k + 1 == dir_rows.size() || dir_rows[k + 1].kind != ROW_CFG)
                    i_cfg_we <= 1'b0;
            end else begin
                if (k + 1 < dir_rows.size() && dir_rows[k + 1].kind == ROW_ITEM)
                    gap = $urandom_range(0, 3);
                else
                    gap = $urandom_range(1, 4);
                push_item(dir_rows[k].item, dir_rows[k].has_known, dir_rows[k].known, gap);
            end
        end

        // Random phases, each with its own register settings.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            case ($urandom_range(0, 4))
                0:       base_pick = 24'd0;
                1:       base_pick = 24'hFFFFFF;
                2:       base_pick = BASE_RESET;
                3:       base_pick = 24'($urandom_range(0, 2097152));
                default: base_pick = 24'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0:       span_pick = 24'd1;
                1:       span_pick = 24'hFFFFFF;
                2:       span_pick = SPAN_RESET;
                3:       span_pick = 24'($urandom_range(1, 65535));
                default: span_pick = 24'($urandom_range(1, 24'hFFFFFF));
            endcase
            write_reg(CFG_ENABLED, (ph == 3 || $urandom_range(0, 5) == 0) ? 24'd0 : 24'd1);
            write_reg(CFG_BASE, base_pick);
            write_reg(CFG_SPAN, span_pick);
            i_cfg_we <= 1'b0;
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                // Bursts of back-to-back items separated by short or long gaps.
                if (burst_left > 0) begin
                    burst_left--;
                    gap = 0;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(1, 12);
                end
                if (j == PHASE_ITEMS - 1 && gap == 0) gap = 1;
                push_item(gen_item(), 1'b0, '0, gap);
            end
        end

        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
